### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define CFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cfs assertion failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define CFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cfs assertion failed");

`endif

### rtl/cfs_pkg.sv
// Package for the clause flip selector: field widths, defaults, state type.
package cfs_pkg;

    localparam int VAR_FIELD_BITS   = 16;
    localparam int RND_BITS         = 31;
    localparam int DEF_MAX_LITERALS = 64;
    localparam int DEF_VAR_BITS     = 16;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_READ = 4'b0100,
        ST_LOAD = 4'b1000
    } cfs_state_t;

endpackage

### rtl/clause_flip_selector.sv
// Clause flip selector: picks variables to flip so a clause reaches its goal.
// Timing: each literal's result is registered in the cycle after accept, except
//   the last literal of an unmet clause, which runs the bit-serial modulo unit over
//   the RND_BITS (31) dividend bits, then the store read (ST_READ, ST_LOAD).
// Throughput: one literal per cycle while results drain; none is taken during a pick.
// Reset: synchronous, active-low aresetn clears control state; store is not cleared.
module clause_flip_selector
    import cfs_pkg::*;
#(
    parameter int MAX_LITERALS = DEF_MAX_LITERALS,
    parameter int VAR_BITS     = DEF_VAR_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input beat: one clause literal
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [VAR_FIELD_BITS-1:0] s_literal_var,
    input  logic                      s_literal_positive,
    input  logic                      s_atom_value,
    input  logic                      s_is_conjunction,
    input  logic                      s_make_true,
    input  logic [RND_BITS-1:0]       s_random_word,
    input  logic                      s_last_literal,
    // result beat
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_flip_valid,
    output logic [VAR_FIELD_BITS-1:0] m_flip_var,
    output logic                      m_clause_done
);

    // count holds 0..MAX_LITERALS, address holds 0..MAX_LITERALS-1
    localparam int CW     = $clog2(MAX_LITERALS + 1);
    localparam int AW     = (MAX_LITERALS > 1) ? $clog2(MAX_LITERALS) : 1;
    localparam int STEP_W = $clog2(RND_BITS);

    cfs_state_t state_reg, state_next;

    // clause context
    logic          in_clause_reg, in_clause_next;
    logic          kind_reg, kind_next;
    logic          goal_reg, goal_next;
    logic          met_reg, met_next;
    logic [CW-1:0] count_reg, count_next;

    // modulo unit: restoring remainder, one dividend bit per cycle
    logic [RND_BITS-1:0] dvd_reg, dvd_next;
    logic [CW-1:0]       dvs_reg, dvs_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    // result register
    logic                      m_valid_reg, m_valid_next;
    logic                      m_flip_valid_reg, m_flip_valid_next;
    logic [VAR_FIELD_BITS-1:0] m_flip_var_reg, m_flip_var_next;
    logic                      m_clause_done_reg, m_clause_done_next;

    // per-beat decode
    logic          s_fire;
    logic          cur_kind, cur_goal, cur_met, truth;
    logic [CW-1:0] count_base, count_new;
    logic          met_new;
    logic          store_mode, wr_en, pick;
    logic [CW:0]   trial;

    // store signals
    logic [VAR_BITS-1:0] wr_var;
    logic [VAR_BITS-1:0] rd_var;
    logic                rd_en;

    // take a new literal only when the sequencer is free and the result slot drains
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        // a fresh clause latches kind and goal from its first literal
        cur_kind   = in_clause_reg ? kind_reg : s_is_conjunction;
        cur_goal   = in_clause_reg ? goal_reg : s_make_true;
        cur_met    = in_clause_reg && met_reg;
        count_base = in_clause_reg ? count_reg : '0;
        truth      = (s_atom_value == s_literal_positive);
        store_mode = (cur_kind != cur_goal);
        // saturate the count once the store is full
        wr_en      = store_mode && (count_base < CW'(MAX_LITERALS));
        count_new  = count_base + CW'(wr_en);
        met_new    = cur_met || (store_mode && (truth == cur_goal));
        pick       = store_mode && s_last_literal && !met_new && (count_new != '0);
        // mask the variable to the stored width
        wr_var     = VAR_BITS'(s_literal_var);
    end

    always_comb begin
        trial = {rem_reg, dvd_reg[RND_BITS-1]};
    end

    always_comb begin
        state_next         = state_reg;
        in_clause_next     = in_clause_reg;
        kind_next          = kind_reg;
        goal_next          = goal_reg;
        met_next           = met_reg;
        count_next         = count_reg;
        dvd_next           = dvd_reg;
        dvs_next           = dvs_reg;
        rem_next           = rem_reg;
        step_next          = step_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_flip_valid_next  = m_flip_valid_reg;
        m_flip_var_next    = m_flip_var_reg;
        m_clause_done_next = m_clause_done_reg;
        rd_en              = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    kind_next = cur_kind;
                    goal_next = cur_goal;
                    if (s_last_literal) begin
                        // end of clause: drop the context
                        in_clause_next = 1'b0;
                        count_next     = '0;
                        met_next       = 1'b0;
                    end else begin
                        in_clause_next = 1'b1;
                        count_next     = count_new;
                        met_next       = met_new;
                    end
                    if (pick) begin
                        // start the modulo: random word % count
                        dvd_next   = s_random_word;
                        dvs_next   = count_new;
                        rem_next   = '0;
                        step_next  = STEP_W'(RND_BITS - 1);
                        state_next = ST_DIV;
                    end else begin
                        m_valid_next       = 1'b1;
                        m_clause_done_next = s_last_literal;
                        if (!store_mode && (truth != cur_goal)) begin
                            m_flip_valid_next = 1'b1;
                            m_flip_var_next   = VAR_FIELD_BITS'(wr_var);
                        end else begin
                            m_flip_valid_next = 1'b0;
                            m_flip_var_next   = '0;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (trial >= {1'b0, dvs_reg}) begin
                    rem_next = CW'(trial - {1'b0, dvs_reg});
                end else begin
                    rem_next = trial[CW-1:0];
                end
                dvd_next  = {dvd_reg[RND_BITS-2:0], 1'b0};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // issue the store read at the remainder
                rd_en      = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                m_valid_next       = 1'b1;
                m_flip_valid_next  = 1'b1;
                m_flip_var_next    = VAR_FIELD_BITS'(rd_var);
                m_clause_done_next = 1'b1;
                state_next         = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_clause_reg <= 1'b0;
            kind_reg      <= 1'b0;
            goal_reg      <= 1'b0;
            met_reg       <= 1'b0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_clause_reg <= in_clause_next;
            kind_reg      <= kind_next;
            goal_reg      <= goal_next;
            met_reg       <= met_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg           <= dvd_next;
        dvs_reg           <= dvs_next;
        rem_reg           <= rem_next;
        step_reg          <= step_next;
        m_flip_valid_reg  <= m_flip_valid_next;
        m_flip_var_reg    <= m_flip_var_next;
        m_clause_done_reg <= m_clause_done_next;
    end

    // literal store; written on an accepted literal in store mode while not full, read once per pick
    cfs_ram #(
        .WIDTH (VAR_BITS),
        .DEPTH (MAX_LITERALS),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (s_fire && wr_en),
        .waddr (count_base[AW-1:0]),
        .wdata (wr_var),
        .re    (rd_en),
        .raddr (rem_reg[AW-1:0]),
        .rdata (rd_var)
    );

    assign m_valid       = m_valid_reg;
    assign m_flip_valid  = m_flip_valid_reg;
    assign m_flip_var    = m_flip_var_reg;
    assign m_clause_done = m_clause_done_reg;

endmodule

### rtl/cfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/cfs_checker.sv
// Port-level checker for the clause flip selector, bound to the top level.
`include "assert_macros.svh"

module cfs_checker
    import cfs_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_flip_valid,
    input logic [VAR_FIELD_BITS-1:0] m_flip_var,
    input logic                      m_clause_done
);

    // a stalled result beat holds
    `CFS_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_flip_var) && $stable(m_flip_valid) && $stable(m_clause_done))

    // no flip means a zero variable
    `CFS_ASSERT_NOW(a_novar_zero, m_valid && !m_flip_valid, m_flip_var == '0)

    // never take a literal while a stalled result still occupies the slot
    `CFS_ASSERT_NOW(a_ready_slot, s_ready && m_valid, m_ready)

    // a literal taken while a result drains: a stall blocks input next cycle
    `CFS_ASSERT_NEXT(a_busy_after, s_valid && s_ready && m_valid && m_ready, !(s_ready && m_valid && !m_ready))

endmodule

bind clause_flip_selector cfs_checker u_cfs_checker (.*);
